// ===== rtl/core/smtq_pkg.sv =====
// Shared constants, codes and types of the servo motion task queue.
package smtq_pkg;

  localparam int QueueDepth  = 8;
  localparam int NumChannels = 16;
  localparam int MaxResults  = 8;

  localparam int ChW    = 4;
  localparam int AngW   = 8;
  localparam int PulseW = 12;
  localparam int DelayW = 16;
  localparam int TimeW  = 32;

  localparam int QIdxW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW   = $clog2(QueueDepth + 1);
  localparam int ResCntW = $clog2(MaxResults + 1);

  localparam logic [AngW-1:0] FullAngle  = 8'd180;
  localparam logic [AngW-1:0] StartAngle = 8'd90;

  // x/180 = (x>>2)/45, and /45 is a multiply by ceil(2^24/45) then >>24
  localparam int              MulW       = 20;
  localparam logic [MulW-1:0] RecipDiv45 = 20'd372828;
  localparam int              RecipShift = 24;

  localparam logic [PulseW-1:0] PulseZeroReset = 12'd150;
  localparam logic [PulseW-1:0] PulseFullReset = 12'd600;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgPulseZero = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPulseFull = 1'b1;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdMove = 1'b1;

  localparam logic [7:0] MoveImmediate = 8'd0;
  localparam logic [7:0] MoveSmoothLo  = 8'd1;
  localparam logic [7:0] MoveSmoothHi  = 8'd2;

  typedef enum logic [1:0] {
    KindAnswer = 2'd0,
    KindUpdate = 2'd1,
    KindIdle   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StReq,
    StRead,
    StMul1,
    StMul2,
    StPulse,
    StFinish
  } state_e;

  typedef struct packed {
    logic              command;
    logic [7:0]        channel;
    logic [AngW-1:0]   target_angle;
    logic [7:0]        move_type;
    logic [DelayW-1:0] step_delay_ms;
  } cmd_t;

  typedef struct packed {
    logic [ChW-1:0]    channel;
    logic [AngW-1:0]   target;
    logic              is_smooth;
    logic [DelayW-1:0] delay;
    logic [AngW-1:0]   angle;
    logic [TimeW-1:0]  last_step;
  } entry_t;

  typedef struct packed {
    kind_e             kind;
    logic              accepted;
    logic [ChW-1:0]    channel;
    logic [AngW-1:0]   angle;
    logic [PulseW-1:0] pulse;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/smtq_req_if.sv =====
// Command channel interface: valid/ready plus one move request or tick.
interface smtq_req_if;
  import smtq_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        channel;
  logic [AngW-1:0]   target_angle;
  logic [7:0]        move_type;
  logic [DelayW-1:0] step_delay_ms;

  modport source (
    output valid, command, channel, target_angle, move_type, step_delay_ms,
    input  ready
  );
  modport sink (
    input  valid, command, channel, target_angle, move_type, step_delay_ms,
    output ready
  );
endinterface

// ===== rtl/core/smtq_res_if.sv =====
// Result channel interface: valid/ready plus one answer or position update.
interface smtq_res_if;
  import smtq_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              accepted;
  logic [ChW-1:0]    out_channel;
  logic [AngW-1:0]   out_angle;
  logic [PulseW-1:0] pulse;
  logic              last;

  modport source (
    output valid, kind, accepted, out_channel, out_angle, pulse, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, out_channel, out_angle, pulse, last,
    output ready
  );
endinterface

// ===== rtl/core/smtq_mul.sv =====
// Shared unsigned multiplier with registered product.
module smtq_mul (
  input  logic                          clk_i,
  input  logic [smtq_pkg::MulW-1:0]     a_i,
  input  logic [smtq_pkg::MulW-1:0]     b_i,
  output logic [2*smtq_pkg::MulW-1:0]   p_o
);
  import smtq_pkg::*;

  logic [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

// ===== rtl/core/smtq_queue.sv =====
// Task queue entry storage: one write and one read port.
module smtq_queue (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [smtq_pkg::QIdxW-1:0]  wr_idx_i,
  input  smtq_pkg::entry_t            wr_entry_i,
  input  logic [smtq_pkg::QIdxW-1:0]  rd_idx_i,
  output smtq_pkg::entry_t            rd_entry_o
);
  import smtq_pkg::*;

  entry_t entries_q [QueueDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entries_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = entries_q[rd_idx_i];
endmodule

// ===== rtl/core/servo_motion_task_queue.sv =====
// Servo motion task queue top level: sequencer, channel angles and result register.
//
//  channel | dir | contents
//  req_i   | in  | command (tick/move), channel, target_angle, move_type, step_delay_ms
//  res_o   | out | kind, accepted, out_channel, out_angle, pulse, last
//  cfg_*   | in  | pulse_at_zero_deg (idx 0), pulse_at_180_deg (idx 1)
//
// A move request is checked and answered from StReq. A tick walks every queued task once,
// the reported updates sharing one multiplier twice each (angle*span, then reciprocal of 45 on that product >>2).
// req_i.ready is high only between transactions; one result may wait in the output
// register while the next transaction is taken. A stalled res_o holds the sequencer.
// Reset clears the queue, time, and sets every channel angle to 90.
module servo_motion_task_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smtq_req_if.sink                      req_i,
  smtq_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [smtq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smtq_pkg::PulseW-1:0]   cfg_wdata_i
);
  import smtq_pkg::*;

  state_e              state_q, state_d;
  logic [TimeW-1:0]    time_q, time_d;
  logic [QCntW-1:0]    count_q, count_d;
  logic [QCntW-1:0]    r_q, r_d;
  logic [QCntW-1:0]    w_q, w_d;
  logic [ResCntW-1:0]  n_q, n_d;
  cmd_t                cmd_q, cmd_d;
  logic [ChW-1:0]      upd_ch_q, upd_ch_d;
  logic [AngW-1:0]     upd_ang_q, upd_ang_d;
  res_t                pend_q, pend_d;
  logic                pend_vld_q, pend_vld_d;
  res_t                out_q, out_d;
  logic                out_vld_q, out_vld_d;
  logic [AngW-1:0]     chan_angle_q [NumChannels];
  logic [AngW-1:0]     chan_angle_d [NumChannels];
  logic [PulseW-1:0]   lo_q, hi_q;

  logic                q_we;
  logic [QIdxW-1:0]    q_wr_idx;
  entry_t              q_wr;
  entry_t              q_rd;
  logic [MulW-1:0]     mul_a, mul_b;
  logic [2*MulW-1:0]   mul_p;

  logic                out_free;
  logic                span_neg;
  logic [PulseW-1:0]   span_mag;
  logic [PulseW-1:0]   quot;
  logic [PulseW-1:0]   pulse_val;
  logic                reject;
  logic [QCntW-1:0]    slot;
  logic [TimeW-1:0]    age;
  logic                moved, done;
  logic [AngW-1:0]     new_ang;
  entry_t              upd_e;
  res_t                new_res;

  smtq_queue u_queue (
    .clk_i      (clk_i),
    .we_i       (q_we),
    .wr_idx_i   (q_wr_idx),
    .wr_entry_i (q_wr),
    .rd_idx_i   (r_q[QIdxW-1:0]),
    .rd_entry_o (q_rd)
  );

  smtq_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign span_neg  = hi_q < lo_q;
  assign span_mag  = span_neg ? (lo_q - hi_q) : (hi_q - lo_q);
  assign quot      = mul_p[RecipShift +: PulseW];
  assign pulse_val = span_neg ? (lo_q - quot) : (lo_q + quot);
  assign out_free  = !out_vld_q || res_o.ready;

  always_comb begin
    new_res          = '0;
    new_res.kind     = KindUpdate;
    new_res.channel  = upd_ch_q;
    new_res.angle    = upd_ang_q;
    new_res.pulse    = pulse_val;
  end

  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    count_d      = count_q;
    r_d          = r_q;
    w_d          = w_q;
    n_d          = n_q;
    cmd_d        = cmd_q;
    upd_ch_d     = upd_ch_q;
    upd_ang_d    = upd_ang_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    chan_angle_d = chan_angle_q;
    q_we         = 1'b0;
    q_wr_idx     = w_q[QIdxW-1:0];
    q_wr         = q_rd;
    mul_a        = '0;
    mul_b        = '0;
    reject       = 1'b0;
    slot         = count_q;
    age          = time_q - q_rd.last_step;
    moved        = 1'b0;
    done         = 1'b0;
    new_ang      = q_rd.angle;
    upd_e        = q_rd;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          cmd_d.command       = req_i.command;
          cmd_d.channel       = req_i.channel;
          cmd_d.target_angle  = req_i.target_angle;
          cmd_d.move_type     = req_i.move_type;
          cmd_d.step_delay_ms = req_i.step_delay_ms;
          if (req_i.command == CmdMove) begin
            state_d = StReq;
          end else begin
            time_d     = time_q + 1'b1;
            r_d        = '0;
            w_d        = '0;
            n_d        = '0;
            pend_vld_d = 1'b0;
            state_d    = StRead;
          end
        end
      end

      StReq: begin
        reject = (cmd_q.channel >= 8'(NumChannels)) || (cmd_q.target_angle > FullAngle) ||
                 (cmd_q.move_type > MoveSmoothHi) || (count_q >= QCntW'(QueueDepth));
        slot   = (cmd_q.move_type != MoveSmoothLo) ? '0 : count_q;
        if (out_free) begin
          out_d          = '0;
          out_d.kind     = KindAnswer;
          out_d.accepted = !reject;
          out_d.last     = 1'b1;
          out_vld_d      = 1'b1;
          if (!reject) begin
            q_we             = 1'b1;
            q_wr_idx         = slot[QIdxW-1:0];
            q_wr.channel     = cmd_q.channel[ChW-1:0];
            q_wr.target      = cmd_q.target_angle;
            q_wr.is_smooth   = cmd_q.move_type != MoveImmediate;
            q_wr.delay       = cmd_q.step_delay_ms;
            q_wr.angle       = chan_angle_q[cmd_q.channel[ChW-1:0]];
            q_wr.last_step   = time_q;
            count_d          = slot + 1'b1;
          end
          state_d = StIdle;
        end
      end

      StRead: begin
        if (r_q == count_q) begin
          count_d = w_q;
          state_d = StFinish;
        end else begin
          if (!q_rd.is_smooth) begin
            new_ang = q_rd.target;
            moved   = 1'b1;
            done    = 1'b1;
          end else if (q_rd.angle == q_rd.target) begin
            done = 1'b1;
          end else if (age >= TimeW'(q_rd.delay)) begin
            new_ang         = (q_rd.target > q_rd.angle) ? (q_rd.angle + 1'b1)
                                                         : (q_rd.angle - 1'b1);
            moved           = 1'b1;
            done            = new_ang == q_rd.target;
            upd_e.angle     = new_ang;
            upd_e.last_step = time_q;
          end
          if (!done) begin
            q_we     = 1'b1;
            q_wr_idx = w_q[QIdxW-1:0];
            q_wr     = upd_e;
            w_d      = w_q + 1'b1;
          end
          r_d = r_q + 1'b1;
          if (moved) begin
            chan_angle_d[q_rd.channel] = new_ang;
            if (n_q < ResCntW'(MaxResults)) begin
              upd_ch_d  = q_rd.channel;
              upd_ang_d = new_ang;
              state_d   = StMul1;
            end
          end
        end
      end

      // product is not held, so wait here until the result will have room
      StMul1: begin
        mul_a = MulW'(upd_ang_q);
        mul_b = MulW'(span_mag);
        if (!pend_vld_q || out_free) begin
          state_d = StMul2;
        end
      end

      StMul2: begin
        mul_a   = MulW'(mul_p[MulW-1:2]);
        mul_b   = RecipDiv45;
        state_d = StPulse;
      end

      StPulse: begin
        if (!pend_vld_q) begin
          pend_d     = new_res;
          pend_vld_d = 1'b1;
          n_d        = n_q + 1'b1;
          state_d    = StRead;
        end else if (out_free) begin
          out_d     = pend_q;
          out_vld_d = 1'b1;
          pend_d    = new_res;
          n_d       = n_q + 1'b1;
          state_d   = StRead;
        end
      end

      StFinish: begin
        if (out_free) begin
          if (pend_vld_q) begin
            out_d = pend_q;
          end else begin
            out_d      = '0;
            out_d.kind = KindIdle;
          end
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      time_q     <= '0;
      count_q    <= '0;
      r_q        <= '0;
      w_q        <= '0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        chan_angle_q[i] <= StartAngle;
      end
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      count_q      <= count_d;
      r_q          <= r_d;
      w_q          <= w_d;
      n_q          <= n_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
      chan_angle_q <= chan_angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    upd_ch_q  <= upd_ch_d;
    upd_ang_q <= upd_ang_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= PulseZeroReset;
      hi_q <= PulseFullReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPulseZero: lo_q <= cfg_wdata_i;
        CfgPulseFull: hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign req_i.ready       = state_q == StIdle;
  assign res_o.valid       = out_vld_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.accepted    = out_q.accepted;
  assign res_o.out_channel = out_q.channel;
  assign res_o.out_angle   = out_q.angle;
  assign res_o.pulse       = out_q.pulse;
  assign res_o.last        = out_q.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue count above depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q <= r_q)
    else $error("compaction write index passed read index");

  a_report_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ResCntW'(MaxResults))
    else $error("reported updates above limit");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind != KindUpdate) |-> out_q.last)
    else $error("answer or idle result without last");

  a_accept_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.accepted |-> out_q.kind == KindAnswer)
    else $error("accepted flag on a non-answer result");
endmodule
